// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/sha256_pkg.sv
// SHA-256 hasher package: word types, round constants, initial hash, sigma functions.
// No dependencies.
package sha256_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [0:7] state_words_t;

    typedef struct packed {
        logic       load_byte;
        logic [7:0] byte_val;
        logic       round_shift;
    } sched_ctrl_t;

    localparam int BLK_BITS = 512;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam state_words_t HASH_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam word_t [0:63] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic word_t big_sig0(word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sig1(word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sig0(word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sig1(word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// File: hdl/sha256_round.sv
// SHA-256 round unit: one compression round on the working variables.
// Depends on sha256_pkg.
module sha256_round
    import sha256_pkg::*;
(
    input  state_words_t vars_in,
    input  word_t        k,
    input  word_t        w,
    output state_words_t vars_out
);

    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    always_comb
    begin
        ch  = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
        maj = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2])
            ^ (vars_in[1] & vars_in[2]);
        t1  = vars_in[7] + big_sig1(vars_in[4]) + ch + k + w;
        t2  = big_sig0(vars_in[0]) + maj;
        vars_out[0] = t1 + t2;
        vars_out[1] = vars_in[0];
        vars_out[2] = vars_in[1];
        vars_out[3] = vars_in[2];
        vars_out[4] = vars_in[3] + t1;
        vars_out[5] = vars_in[4];
        vars_out[6] = vars_in[5];
        vars_out[7] = vars_in[6];
    end

endmodule

// File: hdl/sha256_sched.sv
// SHA-256 block buffer and rolling message schedule as a 16-word shift line.
// Depends on sha256_pkg.
module sha256_sched
    import sha256_pkg::*;
(
    input  logic        clk,
    input  sched_ctrl_t ctrl,
    output word_t       w0
);

    logic [BLK_BITS-1:0] blk_reg;
    logic [BLK_BITS-1:0] blk_next;
    word_t               new_w;

    assign w0 = blk_reg[511:480];

    always_comb
    begin
        new_w = small_sig1(blk_reg[63:32]) + blk_reg[223:192]
              + small_sig0(blk_reg[479:448]) + blk_reg[511:480];
        blk_next = blk_reg;
        priority if (ctrl.load_byte)
        begin
            blk_next = {blk_reg[503:0], ctrl.byte_val};
        end
        else if (ctrl.round_shift)
        begin
            blk_next = {blk_reg[479:0], new_w};
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

endmodule

// File: hdl/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher top level: sequencer, hash and count registers, output register.
// Depends on sha256_pkg, sha256_sched, sha256_round.
// Byte word: taken in idle; the 64th byte of a block starts 64 rounds and then the hash add.
// Finish word: one pad byte per cycle to the block end, then one or two compressions,
// then 8 digest words, one per cycle unless stalled. Input is taken only while idle.
// Reset (rst_n low, async): idle, initial hash, zero count, no digest word pending.
module sha256_byte_stream_hasher
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_number, zero fill
    output logic        m_axis_tlast    // last_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_RUN  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]   state_reg, state_next;
    logic [5:0]   pos_reg, pos_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic [2:0]   widx_reg, widx_next;
    logic [63:0]  count_reg, count_next;
    logic [63:0]  len_reg, len_next;
    logic         pad_reg, pad_next;
    logic         first_reg, first_next;
    logic         lenok_reg, lenok_next;
    logic         final_reg, final_next;
    state_words_t hash_reg, hash_next;
    state_words_t vars_reg, vars_next;
    logic         out_valid_reg, out_valid_next;
    word_t        out_word_reg, out_word_next;
    logic [2:0]   out_num_reg, out_num_next;
    logic         out_last_reg, out_last_next;

    sched_ctrl_t  sched_ctrl;
    word_t        w0;
    state_words_t vars_round;
    logic [2:0]   len_sel;

    sha256_sched u_sched (
        .clk  (clk),
        .ctrl (sched_ctrl),
        .w0   (w0)
    );

    sha256_round u_round (
        .vars_in  (vars_reg),
        .k        (ROUND_K[rnd_reg]),
        .w        (w0),
        .vars_out (vars_round)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_num_reg, out_word_reg};
    assign m_axis_tlast  = out_last_reg;
    assign len_sel       = ~pos_reg[2:0];

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        rnd_next       = rnd_reg;
        widx_next      = widx_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        pad_next       = pad_reg;
        first_next     = first_reg;
        lenok_next     = lenok_reg;
        final_next     = final_reg;
        hash_next      = hash_reg;
        vars_next      = vars_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_word_next  = out_word_reg;
        out_num_next   = out_num_reg;
        out_last_next  = out_last_reg;
        sched_ctrl     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser)
                    begin
                        len_next   = {count_reg[60:0], 3'b000};
                        first_next = 1'b1;
                        pad_next   = 1'b1;
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        sched_ctrl.load_byte = 1'b1;
                        sched_ctrl.byte_val  = s_axis_tdata;
                        pos_next   = pos_reg + 6'd1;
                        count_next = count_reg + 64'd1;
                        if (pos_reg == 6'd63)
                        begin
                            vars_next  = hash_reg;
                            final_next = 1'b0;
                            rnd_next   = '0;
                            state_next = ST_RUN;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                sched_ctrl.load_byte = 1'b1;
                if (first_reg)
                begin
                    sched_ctrl.byte_val = PAD_MARK;
                    lenok_next = (pos_reg < 6'd56);
                end
                else if (lenok_reg && (pos_reg >= 6'd56))
                begin
                    sched_ctrl.byte_val = len_reg[{len_sel, 3'b000} +: 8];
                end
                pos_next   = pos_reg + 6'd1;
                first_next = 1'b0;
                if (pos_reg == 6'd63)
                begin
                    vars_next  = hash_reg;
                    final_next = lenok_reg && !first_reg;
                    rnd_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                sched_ctrl.round_shift = 1'b1;
                vars_next = vars_round;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + vars_reg[i];
                end
                priority if (final_reg)
                begin
                    widx_next  = '0;
                    state_next = ST_OUT;
                end
                else if (pad_reg)
                begin
                    lenok_next = 1'b1;
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = hash_reg[widx_reg];
                    out_num_next   = widx_reg;
                    out_last_next  = (widx_reg == 3'd7);
                    widx_next      = widx_reg + 3'd1;
                    if (widx_reg == 3'd7)
                    begin
                        hash_next  = HASH_IV;
                        count_next = '0;
                        pos_next   = '0;
                        pad_next   = 1'b0;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            rnd_reg       <= '0;
            widx_reg      <= '0;
            count_reg     <= '0;
            pad_reg       <= 1'b0;
            first_reg     <= 1'b0;
            lenok_reg     <= 1'b0;
            final_reg     <= 1'b0;
            hash_reg      <= HASH_IV;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            rnd_reg       <= rnd_next;
            widx_reg      <= widx_next;
            count_reg     <= count_next;
            pad_reg       <= pad_next;
            first_reg     <= first_next;
            lenok_reg     <= lenok_next;
            final_reg     <= final_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        vars_reg     <= vars_next;
        out_word_reg <= out_word_next;
        out_num_reg  <= out_num_next;
        out_last_reg <= out_last_next;
    end

endmodule

// File: hdl/sha256_checker.sv
// Port-level checker for the SHA-256 byte stream hasher, bound to the top level.
// Depends on assert_macros.svh and sha256_byte_stream_hasher.
`include "assert_macros.svh"

module sha256_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic in_fin;
    logic out_stall;

    assign in_fin    = s_axis_tvalid && s_axis_tready && s_axis_tuser && (s_axis_tdata == s_axis_tdata);
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    `CHK_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid, "output word dropped while stalled")
    `CHK_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(m_axis_tdata), "output word changed while stalled")
    `CHK_IMPLY(a_last_num, clk, rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[34:32] == 3'd7), "tlast not on word 7")
    `CHK_NEXT(a_fin_busy, clk, rst_n, in_fin, !s_axis_tready, "ready right after finish word")

endmodule

bind sha256_byte_stream_hasher sha256_checker u_sha256_checker (.*);

// File: tb/sha256_byte_stream_hasher_tb.sv
// Self-checking testbench for sha256_byte_stream_hasher: byte and finish words in, digest words out.
// Predicts digests with its own SHA-256 model, except typed-in ones; depends only on the RTL.
module sha256_byte_stream_hasher_tb;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int RANDOM_WORDS   = 40;

    localparam logic [255:0] NO_DIGEST    = '0;
    localparam logic [255:0] DIGEST_EMPTY =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] DIGEST_ABC   =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    localparam logic [0:7][31:0] CHAIN_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [0:63][31:0] RK = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    typedef struct packed {
        logic         kind;
        logic [7:0]   data;
        logic         known;
        logic [255:0] digest;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  number;
        logic        last;
    } digest_entry_t;

    // digest typed in only for the empty message and "abc"
    localparam stim_row_t [0:15] DIRECTED_ROWS = '{
        '{KIND_FINISH, 8'h00, 1'b1, DIGEST_EMPTY},
        '{KIND_FINISH, 8'hff, 1'b1, DIGEST_EMPTY},
        '{KIND_APPEND, 8'h61, 1'b0, NO_DIGEST},
        '{KIND_APPEND, 8'h62, 1'b0, NO_DIGEST},
        '{KIND_APPEND, 8'h63, 1'b0, NO_DIGEST},
        '{KIND_FINISH, 8'h5a, 1'b1, DIGEST_ABC},
        '{KIND_APPEND, 8'h00, 1'b0, NO_DIGEST},
        '{KIND_APPEND, 8'hff, 1'b0, NO_DIGEST},
        '{KIND_APPEND, 8'h80, 1'b0, NO_DIGEST},
        '{KIND_APPEND, 8'h7f, 1'b0, NO_DIGEST},
        '{KIND_FINISH, 8'h00, 1'b0, NO_DIGEST},
        '{KIND_APPEND, 8'hff, 1'b0, NO_DIGEST},
        '{KIND_FINISH, 8'hff, 1'b0, NO_DIGEST},
        '{KIND_APPEND, 8'h55, 1'b0, NO_DIGEST},
        '{KIND_APPEND, 8'haa, 1'b0, NO_DIGEST},
        '{KIND_FINISH, 8'haa, 1'b0, NO_DIGEST}};

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] digest_word, [34:32] word_number, zero fill
    logic        m_axis_tlast;

    logic [31:0] chain_words [8];
    logic [7:0]  pending_block [64];
    logic [63:0] bytes_absorbed;

    digest_entry_t digest_words_due [$];

    bit failed = 1'b0;
    int sender_idle_pct = 33;
    int receiver_idle_pct = 33;
    int digests_seen = 0;
    bit holdoff_done = 1'b0;

    sha256_byte_stream_hasher u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_chain();
        int i;
        for (i = 0; i < 8; i++)
            chain_words[i] = CHAIN_INIT[i];
        for (i = 0; i < 64; i++)
            pending_block[i] = 8'h00;
        bytes_absorbed = '0;
    endtask

    task automatic compress_pending_block();
        logic [31:0] sched [16];
        logic [31:0] v [8];
        logic [31:0] wr;
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] w2;
        logic [31:0] w15;
        int r;
        for (r = 0; r < 8; r++)
            v[r] = chain_words[r];
        for (r = 0; r < 64; r++)
        begin
            if (r < 16)
                wr = {pending_block[4*r], pending_block[4*r+1],
                      pending_block[4*r+2], pending_block[4*r+3]};
            else
            begin
                w2  = sched[(r - 2) % 16];
                w15 = sched[(r - 15) % 16];
                wr = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + sched[(r - 7) % 16]
                   + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + sched[r % 16];
            end
            sched[r % 16] = wr;
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + wr;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (r = 0; r < 8; r++)
            chain_words[r] = chain_words[r] + v[r];
    endtask

    task automatic absorb_word(input logic kind, input logic [7:0] data,
                               input logic known, input logic [255:0] digest);
        logic [63:0] bit_len;
        digest_entry_t entry;
        int pos;
        int i;
        pos = int'(bytes_absorbed[5:0]);
        if (kind == KIND_APPEND)
        begin
            pending_block[pos] = data;
            bytes_absorbed = bytes_absorbed + 64'd1;
            if (pos == 63)
                compress_pending_block();
        end
        else
        begin
            bit_len = bytes_absorbed << 3;
            pending_block[pos] = 8'h80;
            pos++;
            if (pos > 56)
            begin
                for (i = pos; i < 64; i++)
                    pending_block[i] = 8'h00;
                compress_pending_block();
                pos = 0;
            end
            for (i = pos; i < 56; i++)
                pending_block[i] = 8'h00;
            for (i = 0; i < 8; i++)
                pending_block[56 + i] = bit_len[63 - 8*i -: 8];
            compress_pending_block();
            for (i = 0; i < 8; i++)
            begin
                entry.word   = known ? digest[255 - 32*i -: 32] : chain_words[i];
                entry.number = i[2:0];
                entry.last   = (i == 7);
                digest_words_due.push_back(entry);
            end
            restart_chain();
        end
    endtask

    task automatic send_word(input logic kind, input logic [7:0] data,
                             input logic known, input logic [255:0] digest);
        int gap;
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        absorb_word(kind, data, known, digest);
        @(negedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off while a digest is waiting
    initial
    begin : digest_sink
        int hold_left;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!holdoff_done && digests_seen >= 2 && m_axis_tvalid)
            begin
                holdoff_done = 1'b1;
                hold_left = HOLDOFF_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin : digest_check
        digest_entry_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_words_due.size() == 0)
            begin
                $display("%0t: unexpected digest word %h", $time, m_axis_tdata);
                failed = 1'b1;
            end
            else
            begin
                due = digest_words_due.pop_front();
                if (m_axis_tdata[31:0] !== due.word)
                begin
                    $display("%0t: digest_word expected %h actual %h",
                             $time, due.word, m_axis_tdata[31:0]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[34:32] !== due.number)
                begin
                    $display("%0t: word_number expected %0d actual %0d",
                             $time, due.number, m_axis_tdata[34:32]);
                    failed = 1'b1;
                end
                if (m_axis_tlast !== due.last)
                begin
                    $display("%0t: last_word expected %b actual %b",
                             $time, due.last, m_axis_tlast);
                    failed = 1'b1;
                end
                if (due.last)
                    digests_seen++;
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: cycle limit reached, %0d digest words outstanding",
                 $time, digest_words_due.size());
        $display("sha256_byte_stream_hasher test failed");
        $finish;
    end

    initial
    begin : stimulus
        int long_lengths [$];
        int random_words;
        int msg_len;
        int idx;
        int row;
        int j;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = KIND_APPEND;
        rst_n = 1'b0;
        restart_chain();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (row = 0; row < 16; row++)
            send_word(DIRECTED_ROWS[row].kind, DIRECTED_ROWS[row].data,
                      DIRECTED_ROWS[row].known, DIRECTED_ROWS[row].digest);

        // 120 bytes fills one block, then 56 pending bytes force two-block padding
        long_lengths = '{120};
        random_words = 0;
        while (random_words < RANDOM_WORDS || long_lengths.size() > 0)
        begin
            if (long_lengths.size() > 0 && $urandom_range(0, 2) == 0)
            begin
                idx = $urandom_range(0, long_lengths.size() - 1);
                msg_len = long_lengths[idx];
                long_lengths.delete(idx);
            end
            else
                msg_len = $urandom_range(0, 12);
            for (j = 0; j <= msg_len; j++)
            begin
                if (random_words >= 60 && random_words < 140)
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
                else
                begin
                    sender_idle_pct = 33;
                    receiver_idle_pct = 33;
                end
                if (j < msg_len)
                    send_word(KIND_APPEND, 8'($urandom_range(0, 255)), 1'b0, NO_DIGEST);
                else
                    send_word(KIND_FINISH, 8'($urandom_range(0, 255)), 1'b0, NO_DIGEST);
                random_words++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (digest_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
            $display("sha256_byte_stream_hasher test passed");
        else
            $display("sha256_byte_stream_hasher test failed");
        $finish;
    end

endmodule
